/* src/task_priority_table_defines.svh */
// Assertion macros shared by the task priority table checker.
`ifndef TASK_PRIORITY_TABLE_DEFINES_SVH
`define TASK_PRIORITY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, muted during reset.
`define TPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, muted during reset.
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tpt_pkg.sv */
// Shared types, codes and constants of the task priority table.
package tpt_pkg;

   localparam int DEPTH_DEF = 16;

   typedef enum logic [1:0] {
      ACT_CLEAR     = 2'd0,
      ACT_INS_AUTO  = 2'd1,
      ACT_INS_GIVEN = 2'd2,
      ACT_DELETE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NOTFOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [7:0]  start;
      logic [7:0]  dest;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] assigned_id;
      logic        is_empty;
      logic [4:0]  task_count;
      entry_type   best;
   } result_type;

endpackage

/* src/task_priority_table.sv */
// Top level of the task priority table: sequencer, task memory and result register.
// A clear, or a delete on an empty table, goes straight from idle to the done state; any
// other command first walks the entries (held tasks, after an insert) one by one through
// the memory's single read port.
// One command at a time: a new one is taken only back in idle, and the done state waits
// while the result channel stalls. Reset (synchronous) empties the table and zeroes the auto id.
module task_priority_table #(
   parameter int DEPTH = tpt_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_task_id,
   input  logic [7:0]  req_priority_req,
   input  logic [7:0]  req_start_station,
   input  logic [7:0]  req_dest_station,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_assigned_id,
   output logic        rsp_is_empty,
   output logic [4:0]  rsp_task_count,
   output logic [15:0] rsp_best_id,
   output logic [7:0]  rsp_best_priority,
   output logic [7:0]  rsp_best_start,
   output logic [7:0]  rsp_best_dest
);
   import tpt_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   // Memory port between the sequencer and the task store.
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_rdata;

   // Finished result from the sequencer, waiting for the output register.
   logic       res_valid;
   logic       res_take;
   result_type res;

   // The output register parts the result channel from the sequencer, so the
   // sequencer can return to idle while a result is still waiting for its transfer.
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   tpt_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_task_id       (req_task_id),
      .req_priority_req  (req_priority_req),
      .req_start_station (req_start_station),
      .req_dest_station  (req_dest_station),
      .res_valid         (res_valid),
      .res_take          (res_take),
      .res               (res),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata)
   );

   // Writes and reads never touch the same entry in one cycle: during compaction the
   // write slot always trails the read pointer, and an append lands before the walk.
   tpt_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // A new result may be loaded when the register is empty or is being drained.
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_take) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_assigned_id   = rsp_ff.assigned_id;
   assign rsp_is_empty      = rsp_ff.is_empty;
   assign rsp_task_count    = rsp_ff.task_count;
   assign rsp_best_id       = rsp_ff.best.id;
   assign rsp_best_priority = rsp_ff.best.prio;
   assign rsp_best_start    = rsp_ff.best.start;
   assign rsp_best_dest     = rsp_ff.best.dest;

endmodule

/* src/tpt_store.sv */
// Task memory: one write port and one registered read port.
module tpt_store #(
   parameter int DEPTH = tpt_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      mem_we,
   input  logic [$clog2(DEPTH)-1:0]  mem_waddr,
   input  tpt_pkg::entry_type        mem_wdata,
   input  logic [$clog2(DEPTH)-1:0]  mem_raddr,
   output tpt_pkg::entry_type        mem_rdata
);
   import tpt_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem_ff[mem_raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

/* src/tpt_seq.sv */
// Command sequencer: insert, delete with compaction, and best-task scan over the memory.
module tpt_seq #(
   parameter int DEPTH = tpt_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [15:0]               req_task_id,
   input  logic [7:0]                req_priority_req,
   input  logic [7:0]                req_start_station,
   input  logic [7:0]                req_dest_station,
   output logic                      res_valid,
   input  logic                      res_take,
   output tpt_pkg::result_type       res,
   output logic                      mem_we,
   output logic [$clog2(DEPTH)-1:0]  mem_waddr,
   output tpt_pkg::entry_type        mem_wdata,
   output logic [$clog2(DEPTH)-1:0]  mem_raddr,
   input  tpt_pkg::entry_type        mem_rdata
);
   import tpt_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      auto_id_ff, auto_id_in;
   logic [CNT_W-1:0] scan_n_ff, scan_n_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             data_vld_ff, data_vld_in;
   logic [IDX_W-1:0] data_idx_ff, data_idx_in;
   logic             del_mode_ff, del_mode_in;
   logic             found_ff, found_in;
   logic [15:0]      tid_ff, tid_in;
   status_type       status_ff, status_in;
   logic [15:0]      assigned_ff, assigned_in;
   entry_type        best_ff, best_in;
   logic             have_best_ff, have_best_in;
   logic             match;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      auto_id_in   = auto_id_ff;
      scan_n_in    = scan_n_ff;
      rd_ptr_in    = rd_ptr_ff;
      data_vld_in  = 1'b0;
      data_idx_in  = data_idx_ff;
      del_mode_in  = del_mode_ff;
      found_in     = found_ff;
      tid_in       = tid_ff;
      status_in    = status_ff;
      assigned_in  = assigned_ff;
      best_in      = best_ff;
      have_best_in = have_best_ff;
      match        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = data_idx_ff - IDX_W'(1);
      mem_wdata    = mem_rdata;
      mem_raddr    = rd_ptr_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               have_best_in = 1'b0;
               found_in     = 1'b0;
               rd_ptr_in    = '0;
               tid_in       = req_task_id;
               del_mode_in  = 1'b0;
               assigned_in  = '0;
               status_in    = STAT_OK;
               scan_n_in    = count_ff;
               state_in     = ST_SCAN;
               case (action_type'(req_action))
                  ACT_CLEAR: begin
                     count_in  = '0;
                     scan_n_in = '0;
                  end
                  ACT_INS_AUTO, ACT_INS_GIVEN: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = STAT_FULL;
                     end else begin
                        // Append at the tail; the scan reads it back later.
                        mem_we          = 1'b1;
                        mem_waddr       = count_ff[IDX_W-1:0];
                        mem_wdata.id    = req_task_id;
                        mem_wdata.prio  = req_priority_req;
                        mem_wdata.start = req_start_station;
                        mem_wdata.dest  = req_dest_station;
                        count_in        = count_ff + CNT_W'(1);
                        scan_n_in       = count_ff + CNT_W'(1);
                        if (action_type'(req_action) == ACT_INS_AUTO) begin
                           mem_wdata.id = auto_id_ff;
                           assigned_in  = auto_id_ff;
                           auto_id_in   = auto_id_ff + 16'd1;
                        end
                     end
                  end
                  ACT_DELETE: begin
                     del_mode_in = 1'b1;
                     status_in   = STAT_NOTFOUND;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
               if (scan_n_in == '0) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (rd_ptr_ff < scan_n_ff) begin
               data_vld_in = 1'b1;
               data_idx_in = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
            end
            if (data_vld_ff) begin
               match = del_mode_ff && !found_ff && (mem_rdata.id == tid_ff);
               if (match) begin
                  found_in  = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
                  status_in = STAT_OK;
               end else begin
                  // Entries behind the deleted one move down by one slot.
                  if (found_ff) begin
                     mem_we = 1'b1;
                  end
                  if (!have_best_ff || (mem_rdata.prio > best_ff.prio)) begin
                     best_in      = mem_rdata;
                     have_best_in = 1'b1;
                  end
               end
               if (CNT_W'(data_idx_ff) == scan_n_ff - CNT_W'(1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         auto_id_ff   <= '0;
         scan_n_ff    <= '0;
         rd_ptr_ff    <= '0;
         data_vld_ff  <= 1'b0;
         data_idx_ff  <= '0;
         del_mode_ff  <= 1'b0;
         found_ff     <= 1'b0;
         have_best_ff <= 1'b0;
         status_ff    <= STAT_OK;
         assigned_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         auto_id_ff   <= auto_id_in;
         scan_n_ff    <= scan_n_in;
         rd_ptr_ff    <= rd_ptr_in;
         data_vld_ff  <= data_vld_in;
         data_idx_ff  <= data_idx_in;
         del_mode_ff  <= del_mode_in;
         found_ff     <= found_in;
         have_best_ff <= have_best_in;
         status_ff    <= status_in;
         assigned_ff  <= assigned_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff  <= tid_in;
      best_ff <= best_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign res_valid       = (state_ff == ST_DONE);
   assign res.status      = status_ff;
   assign res.assigned_id = assigned_ff;
   assign res.is_empty    = (count_ff == '0);
   assign res.task_count  = 5'(count_ff);
   assign res.best        = have_best_ff ? best_ff : '0;

endmodule

/* src/tpt_checker.sv */
// Port-level checker for the task priority table, bound to the top level.
`include "task_priority_table_defines.svh"

module tpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_assigned_id,
   input logic        rsp_is_empty,
   input logic [4:0]  rsp_task_count,
   input logic [15:0] rsp_best_id,
   input logic [7:0]  rsp_best_priority,
   input logic [7:0]  rsp_best_start,
   input logic [7:0]  rsp_best_dest
);
   import tpt_pkg::*;

   // A stalled result keeps its payload until the transfer.
   `TPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_assigned_id) && $stable(rsp_task_count) && $stable(rsp_best_id), "result changed while stalled")

   // An empty table reports an all-zero best task.
   `TPT_ASSERT_NOW(a_empty_best, rsp_valid && rsp_is_empty, rsp_best_id == 16'd0 && rsp_best_priority == 8'd0 && rsp_best_start == 8'd0 && rsp_best_dest == 8'd0, "empty table with nonzero best task")

   // A refused insert or a delete miss never hands out an id.
   `TPT_ASSERT_NOW(a_fail_no_id, rsp_valid && (rsp_status == STAT_FULL || rsp_status == STAT_NOTFOUND), rsp_assigned_id == 16'd0, "failed command reports an assigned id")

   // A result with a nonzero best priority cannot come from an empty table.
   `TPT_ASSERT_NOW(a_best_nonempty, rsp_valid && rsp_best_priority != 8'd0, !rsp_is_empty, "best task reported for an empty table")

endmodule

bind task_priority_table tpt_checker u_tpt_checker (.*);
